@@ hw/rtl/dmchc_pkg.sv @@
package dmchc_pkg;

   localparam int unsigned DUR_W     = 7;
   localparam int unsigned TPS_W     = 4;
   localparam int unsigned TEMP_W    = 10;
   localparam int unsigned SAMPLE_W  = 10;
   localparam int unsigned REQ_W     = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 10;

   localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(1000);

   localparam logic [DUR_W-1:0]  LONG_DUR_RST   = DUR_W'(60);
   localparam logic [DUR_W-1:0]  SHORT_DUR_RST  = DUR_W'(10);
   localparam logic [TPS_W-1:0]  TPS_RST        = TPS_W'(4);
   localparam logic [TEMP_W-1:0] HEAT_ON_RST    = TEMP_W'(600);
   localparam logic [TEMP_W-1:0] HEAT_OFF_RST   = TEMP_W'(800);

   typedef enum logic [REQ_W-1:0] {
      REQ_LONG_BTN   = 3'd0,
      REQ_SHORT_BTN  = 3'd1,
      REQ_SEC_TICK   = 3'd2,
      REQ_SHORT_TICK = 3'd3,
      REQ_POLL       = 3'd4
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_DUR  = 3'd0,
      CSR_SHORT_DUR = 3'd1,
      CSR_TPS       = 3'd2,
      CSR_HEAT_ON   = 3'd3,
      CSR_HEAT_OFF  = 3'd4
   } csr_index_type;

   // Scales a raw sample to tenths: sample * 1000 / 1023. The multiply by 1000 is
   // built from shifts, and the divide by 1023 uses the 2^10 - 1 identity with a
   // single remainder correction.
   function automatic logic [TEMP_W-1:0] scale_tenths(input logic [SAMPLE_W-1:0] sample);
      logic [20:0] prod;
      logic [20:0] est;
      logic signed [22:0] rem;
      logic [20:0] quo;
      prod = ({11'd0, sample} << 10) - ({11'd0, sample} << 4) - ({11'd0, sample} << 3);
      est  = (prod + (prod >> 10) + 21'd1) >> 10;
      rem  = $signed({2'b00, prod}) - $signed({2'b00, est << 10}) + $signed({2'b00, est});
      if (rem < 0) begin
         quo = est - 21'd1;
      end else if (rem >= 23'sd1023) begin
         quo = est + 21'd1;
      end else begin
         quo = est;
      end
      return quo[TEMP_W-1:0];
   endfunction

endpackage

@@ hw/rtl/dual_mode_countdown_heater_ctrl_top.sv @@
// Throughput: one word per cycle unless the output stalls; the input register
// holds the raw request, and the sample scaling and the timer and thermostat
// update sit between it and the state and response registers. Reset (synchronous,
// active high) restores the CSR and state registers to their defaults and empties
// the pipeline; no response word is pending after reset.
module dual_mode_countdown_heater_ctrl_top
   import dmchc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [REQ_W-1:0]     req_type,
   input  logic                 req_long_button_level,
   input  logic                 req_short_button_level,
   input  logic [SAMPLE_W-1:0]  req_sensor_sample,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DUR_W-1:0]     rsp_seconds_left,
   output logic                 rsp_is_running,
   output logic                 rsp_in_long_mode,
   output logic                 rsp_heater_on,
   output logic [TEMP_W-1:0]    rsp_temp_tenths,

   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic [DUR_W-1:0]  long_dur_ff;
   logic [DUR_W-1:0]  short_dur_ff;
   logic [TPS_W-1:0]  tps_ff;
   logic [TEMP_W-1:0] heat_on_ff;
   logic [TEMP_W-1:0] heat_off_ff;

   logic                s1_valid_ff;
   logic [REQ_W-1:0]    s1_type_ff;
   logic                s1_long_lvl_ff;
   logic                s1_short_lvl_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [TEMP_W-1:0]   s1_temp;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic              mode_long_ff, mode_long_in;
   logic              run_ff, run_in;
   logic [DUR_W-1:0]  count_ff, count_in;
   logic [TPS_W-1:0]  prescale_ff, prescale_in;
   logic              long_latch_ff, long_latch_in;
   logic              short_latch_ff, short_latch_in;
   logic              heater_ff, heater_in;
   logic [TEMP_W-1:0] temp_ff, temp_in;

   logic              advance;
   logic              s1_fire;
   logic              req_fire;
   logic [TPS_W-1:0]  prescale_inc;
   logic [DUR_W-1:0]  count_dec;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_dur_ff  <= LONG_DUR_RST;
         short_dur_ff <= SHORT_DUR_RST;
         tps_ff       <= TPS_RST;
         heat_on_ff   <= HEAT_ON_RST;
         heat_off_ff  <= HEAT_OFF_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LONG_DUR:  long_dur_ff  <= csr_data[DUR_W-1:0];
            CSR_SHORT_DUR: short_dur_ff <= csr_data[DUR_W-1:0];
            CSR_TPS:       tps_ff       <= csr_data[TPS_W-1:0];
            CSR_HEAT_ON:   heat_on_ff   <= csr_data[TEMP_W-1:0];
            CSR_HEAT_OFF:  heat_off_ff  <= csr_data[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff      <= req_type;
         s1_long_lvl_ff  <= req_long_button_level;
         s1_short_lvl_ff <= req_short_button_level;
         s1_sample_ff    <= req_sensor_sample;
      end
   end

   assign s1_temp      = scale_tenths(s1_sample_ff);
   assign prescale_inc = prescale_ff + TPS_W'(1);
   assign count_dec    = (count_ff != '0) ? count_ff - DUR_W'(1) : '0;

   always_comb begin
      mode_long_in   = mode_long_ff;
      run_in         = run_ff;
      count_in       = count_ff;
      prescale_in    = prescale_ff;
      long_latch_in  = long_latch_ff;
      short_latch_in = short_latch_ff;
      heater_in      = heater_ff;
      temp_in        = temp_ff;
      unique case (s1_type_ff)
         REQ_LONG_BTN: begin
            if (!long_latch_ff) begin
               long_latch_in = 1'b1;
               if (run_ff && mode_long_ff) begin
                  run_in = 1'b0;
               end else begin
                  mode_long_in = 1'b1;
                  count_in     = long_dur_ff;
                  run_in       = 1'b1;
                  prescale_in  = '0;
               end
            end
         end
         REQ_SHORT_BTN: begin
            if (!short_latch_ff) begin
               short_latch_in = 1'b1;
               if (run_ff && !mode_long_ff) begin
                  run_in = 1'b0;
               end else begin
                  mode_long_in = 1'b0;
                  count_in     = short_dur_ff;
                  run_in       = 1'b1;
                  prescale_in  = '0;
               end
            end
         end
         REQ_SEC_TICK: begin
            if (run_ff && mode_long_ff) begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  run_in = 1'b0;
               end
            end
         end
         REQ_SHORT_TICK: begin
            if (run_ff && !mode_long_ff) begin
               if (prescale_inc >= tps_ff) begin
                  prescale_in = '0;
                  count_in    = count_dec;
                  if (count_dec == '0) begin
                     run_in = 1'b0;
                  end
               end else begin
                  prescale_in = prescale_inc;
               end
            end
         end
         REQ_POLL: begin
            if (!s1_long_lvl_ff) begin
               long_latch_in = 1'b0;
            end
            if (!s1_short_lvl_ff) begin
               short_latch_in = 1'b0;
            end
            if (run_ff) begin
               temp_in = s1_temp;
               priority if (s1_temp < heat_on_ff) begin
                  heater_in = 1'b1;
               end else if (s1_temp > heat_off_ff) begin
                  heater_in = 1'b0;
               end else begin
                  heater_in = heater_ff;
               end
            end
         end
         default: ;
      endcase
      if (!run_in) begin
         heater_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_long_ff   <= 1'b1;
         run_ff         <= 1'b0;
         count_ff       <= LONG_DUR_RST;
         prescale_ff    <= '0;
         long_latch_ff  <= 1'b0;
         short_latch_ff <= 1'b0;
         heater_ff      <= 1'b0;
         temp_ff        <= '0;
      end else if (s1_fire) begin
         mode_long_ff   <= mode_long_in;
         run_ff         <= run_in;
         count_ff       <= count_in;
         prescale_ff    <= prescale_in;
         long_latch_ff  <= long_latch_in;
         short_latch_ff <= short_latch_in;
         heater_ff      <= heater_in;
         temp_ff        <= temp_in;
      end
   end

   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seconds_left = count_ff;
   assign rsp_is_running   = run_ff;
   assign rsp_in_long_mode = mode_long_ff;
   assign rsp_heater_on    = heater_ff;
   assign rsp_temp_tenths  = temp_ff;

endmodule

@@ hw/rtl/dmchc_checker.sv @@
module dmchc_checker
   import dmchc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [DUR_W-1:0]     rsp_seconds_left,
   input logic                 rsp_is_running,
   input logic                 rsp_in_long_mode,
   input logic                 rsp_heater_on,
   input logic [TEMP_W-1:0]    rsp_temp_tenths
);

   // A stalled response word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seconds_left)
         && $stable(rsp_is_running) && $stable(rsp_in_long_mode)
         && $stable(rsp_heater_on) && $stable(rsp_temp_tenths))
      else $error("stalled response word changed");

   // The heater is never driven while the timer is stopped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_running |-> !rsp_heater_on)
      else $error("heater on while stopped");

   // The scaled temperature never exceeds full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp_tenths <= TEMP_MAX)
      else $error("temperature out of range");

   // The request side only backs up while a response word is held back.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without downstream stall");

   // No response word survives reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word valid after reset");

endmodule

bind dual_mode_countdown_heater_ctrl_top dmchc_checker u_dmchc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_seconds_left (rsp_seconds_left),
   .rsp_is_running   (rsp_is_running),
   .rsp_in_long_mode (rsp_in_long_mode),
   .rsp_heater_on    (rsp_heater_on),
   .rsp_temp_tenths  (rsp_temp_tenths)
);
